// ===== rtl/packet_protocol_stats_unit_assert.svh =====
`ifndef PACKET_PROTOCOL_STATS_UNIT_ASSERT_SVH
`define PACKET_PROTOCOL_STATS_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante
`define PPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pps assertion failed");

// Check cons in the cycle after ante
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pps assertion failed");

`endif

// ===== rtl/pps_pkg.sv =====
package pps_pkg;

  localparam int COUNTER_ENTRIES = 8;
  localparam int SLOT_W = $clog2(COUNTER_ENTRIES);

  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [15:0] ETYPE_ARP       = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6      = 16'h86DD;
  localparam logic [15:0] ETYPE_PPP_DISC  = 16'h8863;
  localparam logic [15:0] ETYPE_PPP_SESS  = 16'h8864;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
  localparam logic [16:0] IPV4_HDR_LEN = 17'd20;
  localparam logic [16:0] IPV6_HDR_LEN = 17'd40;

  localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
  localparam logic [15:0] IPV6_MIN_LEN = 16'd54;

  typedef enum logic [0:0] {
    OP_ACCOUNT = 1'b0,
    OP_READ    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    SLOT_ALL   = 3'd0,
    SLOT_IPV4  = 3'd1,
    SLOT_IPV6  = 3'd2,
    SLOT_PPPOE = 3'd3,
    SLOT_ICMP  = 3'd4,
    SLOT_TCP   = 3'd5,
    SLOT_UDP   = 3'd6,
    SLOT_SCTP  = 3'd7
  } slot_t;

  typedef logic [63:0] cnt_t;

endpackage

// ===== rtl/packet_protocol_stats_unit.sv =====
// Packet protocol statistics unit.
// Input channel (in_valid/in_ready): one transaction per item. opcode 0
// accounts one frame by ether_type, frame_length and ip_protocol into eight
// packet/byte counter entries; opcode 1 reads the entry named by read_slot.
// Output channel (out_valid/out_ready): one transaction per read item with
// slot_read, packet_total and byte_total. Account items give no result.
// An accepted item enters an input register; in the next cycle an account
// updates the counters, while a read is sampled into the result register
// once that register is free or being taken, and sees every earlier account.
// Throughput is one item per cycle while no read waits in the input
// register; a stalled result holds in the result register, and accounts
// keep flowing until a later read reaches the input register and blocks
// it and the input. The 64-bit counter adders between the input register
// and the counter registers set the cycle time.
// Reset clears all counters and both valid flags; counters wrap at 2^64.
module packet_protocol_stats_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_opcode,
  input  logic [15:0] in_ether_type,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_ip_protocol,
  input  logic [2:0]  in_read_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slot_read,
  output logic [63:0] out_packet_total,
  output logic [63:0] out_byte_total
);

  `include "packet_protocol_stats_unit_assert.svh"

  logic        s1_valid_r;
  logic [0:0]  s1_opcode_r;
  logic [15:0] s1_ether_type_r;
  logic [15:0] s1_frame_length_r;
  logic [7:0]  s1_ip_protocol_r;
  logic [2:0]  s1_read_slot_r;

  logic        out_valid_r;
  logic [2:0]  out_slot_r;
  pps_pkg::cnt_t out_packet_r;
  pps_pkg::cnt_t out_byte_r;

  pps_pkg::cnt_t packet_r [pps_pkg::COUNTER_ENTRIES];
  pps_pkg::cnt_t byte_r   [pps_pkg::COUNTER_ENTRIES];
  pps_pkg::cnt_t packet_nxt [pps_pkg::COUNTER_ENTRIES];
  pps_pkg::cnt_t byte_nxt   [pps_pkg::COUNTER_ENTRIES];

  logic          in_accept;
  logic          s1_is_read;
  logic          s1_adv;
  logic          rd_load;
  logic          acct;
  logic [16:0]   plen;
  logic [16:0]   l3_bytes;
  logic [16:0]   l4_bytes;
  pps_pkg::slot_t l3_slot;
  pps_pkg::slot_t l4_slot;
  logic          l3_known;
  logic          et_unknown;
  logic          l4_hdr_ok;
  logic          l4_known;
  logic [1:0]    pkt_inc  [pps_pkg::COUNTER_ENTRIES];
  logic [17:0]   byte_inc [pps_pkg::COUNTER_ENTRIES];

  assign s1_is_read = (s1_opcode_r == pps_pkg::OP_READ);
  assign s1_adv     = s1_valid_r && (!s1_is_read || !out_valid_r || out_ready);
  assign rd_load    = s1_adv && s1_is_read;
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_accept  = in_valid && in_ready;

  assign acct = s1_valid_r && !s1_is_read &&
                (s1_frame_length_r >= 16'(pps_pkg::ETH_HDR_LEN));
  assign plen     = {1'b0, s1_frame_length_r} + 17'd1;
  assign l3_bytes = plen - pps_pkg::ETH_HDR_LEN;

  always_comb begin
    l3_known = 1'b1;
    unique case (s1_ether_type_r) inside
      pps_pkg::ETYPE_IPV4, pps_pkg::ETYPE_ARP:          l3_slot = pps_pkg::SLOT_IPV4;
      pps_pkg::ETYPE_IPV6:                              l3_slot = pps_pkg::SLOT_IPV6;
      pps_pkg::ETYPE_PPP_DISC, pps_pkg::ETYPE_PPP_SESS: l3_slot = pps_pkg::SLOT_PPPOE;
      default: begin
        l3_slot  = pps_pkg::SLOT_ALL;
        l3_known = 1'b0;
      end
    endcase
  end

  assign et_unknown = !l3_known && (s1_ether_type_r != 16'd0);

  always_comb begin
    l4_known = 1'b1;
    unique case (s1_ip_protocol_r)
      pps_pkg::PROTO_ICMP: l4_slot = pps_pkg::SLOT_ICMP;
      pps_pkg::PROTO_TCP:  l4_slot = pps_pkg::SLOT_TCP;
      pps_pkg::PROTO_UDP:  l4_slot = pps_pkg::SLOT_UDP;
      pps_pkg::PROTO_SCTP: l4_slot = pps_pkg::SLOT_SCTP;
      default: begin
        l4_slot  = pps_pkg::SLOT_ALL;
        l4_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    l4_hdr_ok = 1'b0;
    l4_bytes  = plen - pps_pkg::IPV4_HDR_LEN;
    if (s1_ether_type_r == pps_pkg::ETYPE_IPV4) begin
      l4_hdr_ok = (s1_frame_length_r >= pps_pkg::IPV4_MIN_LEN);
    end else if (s1_ether_type_r == pps_pkg::ETYPE_IPV6) begin
      l4_hdr_ok = (s1_frame_length_r >= pps_pkg::IPV6_MIN_LEN);
      l4_bytes  = plen - pps_pkg::IPV6_HDR_LEN;
    end
  end

  always_comb begin
    for (int i = 0; i < pps_pkg::COUNTER_ENTRIES; i++) begin
      pkt_inc[i]  = 2'd0;
      byte_inc[i] = 18'd0;
      if (acct) begin
        if (i == 0) begin
          pkt_inc[i]  = et_unknown ? 2'd2 : 2'd1;
          byte_inc[i] = {1'b0, plen} + (et_unknown ? {1'b0, l3_bytes} : 18'd0);
        end
        if (l3_known && (pps_pkg::SLOT_W'(i) == pps_pkg::SLOT_W'(l3_slot))) begin
          pkt_inc[i]  = 2'd1;
          byte_inc[i] = {1'b0, l3_bytes};
        end
        if (l4_hdr_ok && l4_known &&
            (pps_pkg::SLOT_W'(i) == pps_pkg::SLOT_W'(l4_slot))) begin
          pkt_inc[i]  = 2'd1;
          byte_inc[i] = {1'b0, l4_bytes};
        end
      end
      packet_nxt[i] = packet_r[i] + 64'(pkt_inc[i]);
      byte_nxt[i]   = byte_r[i] + 64'(byte_inc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pps_pkg::COUNTER_ENTRIES; i++) begin
        packet_r[i] <= '0;
        byte_r[i]   <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (rd_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      for (int i = 0; i < pps_pkg::COUNTER_ENTRIES; i++) begin
        packet_r[i] <= packet_nxt[i];
        byte_r[i]   <= byte_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r       <= in_opcode;
      s1_ether_type_r   <= in_ether_type;
      s1_frame_length_r <= in_frame_length;
      s1_ip_protocol_r  <= in_ip_protocol;
      s1_read_slot_r    <= in_read_slot;
    end
    if (rd_load) begin
      out_slot_r   <= s1_read_slot_r;
      out_packet_r <= packet_r[pps_pkg::SLOT_W'(s1_read_slot_r)];
      out_byte_r   <= byte_r[pps_pkg::SLOT_W'(s1_read_slot_r)];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_read    = out_slot_r;
  assign out_packet_total = out_packet_r;
  assign out_byte_total   = out_byte_r;

  `PPS_ASSERT_NOW(a_read_blocked, s1_valid_r && s1_is_read && out_valid_r && !out_ready,
    !in_ready)
  `PPS_ASSERT_NEXT(a_read_loads, rd_load,
    out_valid_r && (out_slot_r == $past(s1_read_slot_r)))
  `PPS_ASSERT_NEXT(a_acct_counts, acct, packet_r[0] != $past(packet_r[0]))
  `PPS_ASSERT_NEXT(a_short_ignored,
    s1_valid_r && !s1_is_read &&
    (s1_frame_length_r < 16'(pps_pkg::ETH_HDR_LEN)),
    $stable(packet_r[0]) && $stable(byte_r[0]))

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 850;
  localparam int READ_PERCENT = 30;
  localparam int IDLE_PERCENT = 28;
  localparam int GAPLESS_FIRST = 450;
  localparam int GAPLESS_LAST = 600;
  localparam int DRAIN_AT_ITEM = 700;
  localparam int HOLD_FIRST_CYCLE = 300;
  localparam int HOLD_LAST_CYCLE = 560;
  localparam int STEADY_FIRST_CYCLE = 800;
  localparam int STEADY_LAST_CYCLE = 1100;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    pps_pkg::opcode_t op;
    logic [15:0]      ether_type;
    logic [15:0]      frame_len;
    logic [7:0]       proto;
    logic [2:0]       slot;
    bit               typed;
    pps_pkg::cnt_t    typed_pkts;
    pps_pkg::cnt_t    typed_bytes;
  } stim_item_t;

  typedef struct {
    logic [2:0]    slot;
    pps_pkg::cnt_t pkts;
    pps_pkg::cnt_t bytes;
  } read_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [0:0]  in_opcode;
  logic [15:0] in_ether_type;
  logic [15:0] in_frame_length;
  logic [7:0]  in_ip_protocol;
  logic [2:0]  in_read_slot;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_slot_read;
  logic [63:0] out_packet_total;
  logic [63:0] out_byte_total;

  stim_item_t    offered;
  stim_item_t    directed_rows[$];
  read_result_t  pending_reads[$];
  pps_pkg::cnt_t pkt_tally[pps_pkg::COUNTER_ENTRIES];
  pps_pkg::cnt_t byte_tally[pps_pkg::COUNTER_ENTRIES];
  int            fail_count;

  assign in_opcode       = offered.op;
  assign in_ether_type   = offered.ether_type;
  assign in_frame_length = offered.frame_len;
  assign in_ip_protocol  = offered.proto;
  assign in_read_slot    = offered.slot;

  packet_protocol_stats_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_ether_type    (in_ether_type),
    .in_frame_length  (in_frame_length),
    .in_ip_protocol   (in_ip_protocol),
    .in_read_slot     (in_read_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_read    (out_slot_read),
    .out_packet_total (out_packet_total),
    .out_byte_total   (out_byte_total)
  );

  function automatic stim_item_t mk_account(logic [15:0] et, logic [15:0] fl, logic [7:0] pr);
    stim_item_t item;
    item.op          = pps_pkg::OP_ACCOUNT;
    item.ether_type  = et;
    item.frame_len   = fl;
    item.proto       = pr;
    item.slot        = 3'($urandom_range(7));
    item.typed       = 1'b0;
    item.typed_pkts  = '0;
    item.typed_bytes = '0;
    return item;
  endfunction

  function automatic stim_item_t mk_read(pps_pkg::slot_t s, bit typed, pps_pkg::cnt_t pkts,
                                         pps_pkg::cnt_t bytes);
    stim_item_t item;
    item.op          = pps_pkg::OP_READ;
    item.ether_type  = 16'($urandom);
    item.frame_len   = 16'($urandom);
    item.proto       = 8'($urandom);
    item.slot        = s;
    item.typed       = typed;
    item.typed_pkts  = pkts;
    item.typed_bytes = bytes;
    return item;
  endfunction

  function automatic stim_item_t random_item();
    logic [15:0] et;
    logic [15:0] fl;
    logic [7:0]  pr;
    if ($urandom_range(99) < READ_PERCENT)
      return mk_read(pps_pkg::slot_t'($urandom_range(7)), 1'b0, '0, '0);
    case ($urandom_range(9))
      0, 1, 2: et = pps_pkg::ETYPE_IPV4;
      3, 4:    et = pps_pkg::ETYPE_IPV6;
      5:       et = pps_pkg::ETYPE_ARP;
      6:       et = $urandom_range(1) ? pps_pkg::ETYPE_PPP_DISC : pps_pkg::ETYPE_PPP_SESS;
      7:       et = '0;
      default: et = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       fl = 16'($urandom_range(13));
      1:       fl = 16'($urandom_range(60, 30));
      2:       fl = 16'($urandom);
      default: fl = 16'($urandom_range(1600, 14));
    endcase
    case ($urandom_range(9))
      0, 1:    pr = pps_pkg::PROTO_TCP;
      2, 3:    pr = pps_pkg::PROTO_UDP;
      4:       pr = pps_pkg::PROTO_ICMP;
      5:       pr = pps_pkg::PROTO_SCTP;
      default: pr = 8'($urandom);
    endcase
    return mk_account(et, fl, pr);
  endfunction

  function automatic void add_to_slot(pps_pkg::slot_t s, logic [16:0] amount);
    pkt_tally[s]  += 64'd1;
    byte_tally[s] += 64'(amount);
  endfunction

  function automatic pps_pkg::slot_t protocol_slot(logic [7:0] pr);
    case (pr)
      pps_pkg::PROTO_ICMP: return pps_pkg::SLOT_ICMP;
      pps_pkg::PROTO_TCP:  return pps_pkg::SLOT_TCP;
      pps_pkg::PROTO_UDP:  return pps_pkg::SLOT_UDP;
      pps_pkg::PROTO_SCTP: return pps_pkg::SLOT_SCTP;
      default:             return pps_pkg::SLOT_ALL;
    endcase
  endfunction

  function automatic void account_frame(logic [15:0] et, logic [15:0] fl, logic [7:0] pr);
    logic [16:0]    plen;
    pps_pkg::slot_t l3;
    pps_pkg::slot_t l4;
    if ({1'b0, fl} < pps_pkg::ETH_HDR_LEN)
      return;
    plen = {1'b0, fl} + 17'd1;
    add_to_slot(pps_pkg::SLOT_ALL, plen);
    if (et == '0)
      return;
    case (et)
      pps_pkg::ETYPE_IPV4, pps_pkg::ETYPE_ARP:          l3 = pps_pkg::SLOT_IPV4;
      pps_pkg::ETYPE_IPV6:                              l3 = pps_pkg::SLOT_IPV6;
      pps_pkg::ETYPE_PPP_DISC, pps_pkg::ETYPE_PPP_SESS: l3 = pps_pkg::SLOT_PPPOE;
      default:                                          l3 = pps_pkg::SLOT_ALL;
    endcase
    add_to_slot(l3, plen - pps_pkg::ETH_HDR_LEN);
    l4 = protocol_slot(pr);
    if (l4 == pps_pkg::SLOT_ALL)
      return;
    if (et == pps_pkg::ETYPE_IPV4 && fl >= pps_pkg::IPV4_MIN_LEN)
      add_to_slot(l4, plen - pps_pkg::IPV4_HDR_LEN);
    else if (et == pps_pkg::ETYPE_IPV6 && fl >= pps_pkg::IPV6_MIN_LEN)
      add_to_slot(l4, plen - pps_pkg::IPV6_HDR_LEN);
  endfunction

  task automatic offer(stim_item_t item, bit gapless);
    @(negedge clk);
    while (!gapless && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    offered  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int unsigned cycle_count;
    cycle_count = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n)
        cycle_count++;
      if (cycle_count >= HOLD_FIRST_CYCLE && cycle_count < HOLD_LAST_CYCLE)
        out_ready <= 1'b0;
      else if (cycle_count >= STEADY_FIRST_CYCLE && cycle_count < STEADY_LAST_CYCLE)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : scoreboard
    read_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: slot %0d packets %0d bytes %0d",
                     out_slot_read, out_packet_total, out_byte_total);
        end else begin
          want = pending_reads.pop_front();
          if (out_slot_read !== want.slot || out_packet_total !== want.pkts ||
              out_byte_total !== want.bytes) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: exp slot %0d pkts %0d bytes %0d, got slot %0d pkts %0d bytes %0d",
                       want.slot, want.pkts, want.bytes,
                       out_slot_read, out_packet_total, out_byte_total);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (offered.op == pps_pkg::OP_READ) begin
          want.slot  = offered.slot;
          want.pkts  = offered.typed ? offered.typed_pkts : pkt_tally[offered.slot];
          want.bytes = offered.typed ? offered.typed_bytes : byte_tally[offered.slot];
          pending_reads.push_back(want);
        end else begin
          account_frame(offered.ether_type, offered.frame_len, offered.proto);
        end
      end
    end
  end

  initial begin : stimulus
    fail_count = 0;
    for (int s = 0; s < pps_pkg::COUNTER_ENTRIES; s++) begin
      pkt_tally[s]  = '0;
      byte_tally[s] = '0;
    end
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    offered  <= mk_account('0, '0, '0);

    directed_rows.push_back(mk_read(pps_pkg::SLOT_ALL, 1'b1, 64'd0, 64'd0));
    directed_rows.push_back(mk_read(pps_pkg::SLOT_SCTP, 1'b1, 64'd0, 64'd0));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV4, 16'd13, pps_pkg::PROTO_TCP));
    directed_rows.push_back(mk_read(pps_pkg::SLOT_ALL, 1'b1, 64'd0, 64'd0));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV4, 16'd14, pps_pkg::PROTO_TCP));
    directed_rows.push_back(mk_read(pps_pkg::SLOT_ALL, 1'b1, 64'd1, 64'd15));
    directed_rows.push_back(mk_read(pps_pkg::SLOT_IPV4, 1'b1, 64'd1, 64'd1));
    directed_rows.push_back(mk_read(pps_pkg::SLOT_TCP, 1'b1, 64'd0, 64'd0));
    directed_rows.push_back(mk_account(16'h0000, 16'd100, pps_pkg::PROTO_UDP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_ARP, 16'd34, pps_pkg::PROTO_TCP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV6, 16'd54, pps_pkg::PROTO_UDP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV6, 16'd53, pps_pkg::PROTO_ICMP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_PPP_DISC, 16'd60, pps_pkg::PROTO_SCTP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_PPP_SESS, 16'hFFFF, 8'hFF));
    directed_rows.push_back(mk_account(16'hFFFF, 16'hFFFF, pps_pkg::PROTO_TCP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV4, 16'd34, pps_pkg::PROTO_ICMP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV4, 16'hFFFF, pps_pkg::PROTO_SCTP));
    directed_rows.push_back(mk_account(pps_pkg::ETYPE_IPV4, 16'd200, 8'hFF));
    for (int s = 0; s < pps_pkg::COUNTER_ENTRIES; s++)
      directed_rows.push_back(mk_read(pps_pkg::slot_t'(s), 1'b0, '0, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i], 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_AT_ITEM) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge clk);
      end
      offer(random_item(), i >= GAPLESS_FIRST && i < GAPLESS_LAST);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_reads.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/packet_protocol_stats_unit.sv
verif/testbench.sv
